// ----- rtl/core/stat_pkg.sv -----
// Shared types and constants for the section table address translator.
// No dependencies; imported by every module of the block.
package stat_pkg;

	localparam int MAX_SECTIONS_DEFAULT = 16;
	localparam int ADDR_W = 32;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_V2F  = 2'd1,
		OP_F2V  = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDENTITY   = 3'd0,
		ST_TRANSLATED = 3'd1,
		ST_RANGE      = 3'd2,
		ST_NOTFOUND   = 3'd3,
		ST_LOADED     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CFG_HEADER_SIZE   = 2'd0,
		CFG_IMAGE_SIZE    = 2'd1,
		CFG_SECTION_COUNT = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_END_RD,
		S_END_CHK,
		S_RD,
		S_CMP
	} state_t;

	typedef struct packed {
		op_t               op;
		logic [3:0]        entry_index;
		logic [ADDR_W-1:0] entry_virtual_base;
		logic [ADDR_W-1:0] entry_file_base;
		logic [ADDR_W-1:0] entry_file_size;
		logic [ADDR_W-1:0] address;
	} cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0] translated;
		status_t           status;
	} result_t;

	typedef struct packed {
		logic [ADDR_W-1:0] virtual_base;
		logic [ADDR_W-1:0] file_base;
		logic [ADDR_W-1:0] file_size;
	} entry_t;

endpackage

// ----- rtl/core/stat_entry_ram.sv -----
// Section table storage: one write port, one read port with registered data.
// Depends on stat_pkg for the entry type.
module stat_entry_ram #(
	parameter int DEPTH = stat_pkg::MAX_SECTIONS_DEFAULT,
	parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                we,
	input  logic [IDX_W-1:0]    waddr,
	input  stat_pkg::entry_t    wdata,
	input  logic [IDX_W-1:0]    raddr,
	output stat_pkg::entry_t    rdata
);
	import stat_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/section_table_address_translator.sv -----
// Top level of the section table address translator.
// Depends on stat_pkg and stat_entry_ram.
//
// A command beat is taken when start is high and busy is low, and its single result
// appears on result with done high for exactly one cycle; the receiver cannot stall it.
// Loads, the unused op, header identity, virtual addresses beyond the image and an empty
// table are answered in the cycle after the command, with busy staying low. A search
// reads one table entry at a time through the single read port of the section table
// and tests it with one shared compare and rebase unit, starting at the last valid entry.
// Each entry is read in S_RD and tested in S_CMP; a file-to-virtual translation first
// reads the last valid entry in S_END_RD and checks the end of its section in S_END_CHK.
module section_table_address_translator #(
	parameter int MAX_SECTIONS = stat_pkg::MAX_SECTIONS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  stat_pkg::cmd_t    cmd,
	output logic              busy,
	output logic              done,
	output stat_pkg::result_t result,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data
);
	import stat_pkg::*;

	localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] header_size_q;
	logic [ADDR_W-1:0] image_size_q;
	logic [4:0]        section_count_q;
	op_t               op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [IDX_W-1:0]  ptr_q, ptr_d;
	logic              done_q, done_d;
	result_t           result_q, result_d;
	logic [CNT_W-1:0]  valid_cnt;
	logic              accept;
	logic              ram_we;
	entry_t            ram_wdata;
	entry_t            ram_rdata;
	logic [ADDR_W-1:0] from_base, to_base;
	logic [ADDR_W:0]   section_end;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	assign valid_cnt = (32'(section_count_q) > 32'(MAX_SECTIONS)) ?
		CNT_W'(MAX_SECTIONS) : CNT_W'(section_count_q);

	assign ram_wdata = '{virtual_base: cmd.entry_virtual_base,
		file_base: cmd.entry_file_base, file_size: cmd.entry_file_size};

	stat_entry_ram #(
		.DEPTH (MAX_SECTIONS),
		.IDX_W (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (IDX_W'(cmd.entry_index)),
		.wdata (ram_wdata),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	// The shared unit compares against one base and rebases onto the other.
	assign from_base   = (op_q == OP_V2F) ? ram_rdata.virtual_base : ram_rdata.file_base;
	assign to_base     = (op_q == OP_V2F) ? ram_rdata.file_base : ram_rdata.virtual_base;
	assign section_end = {1'b0, ram_rdata.file_base} + {1'b0, ram_rdata.file_size};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_size_q   <= '0;
			image_size_q    <= '0;
			section_count_q <= 5'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HEADER_SIZE:   header_size_q   <= cfg_data;
				CFG_IMAGE_SIZE:    image_size_q    <= cfg_data;
				CFG_SECTION_COUNT: section_count_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q    <= ptr_d;
		result_q <= result_d;
		if (accept) begin
			op_q   <= cmd.op;
			addr_q <= cmd.address;
		end
	end

	always_comb begin
		state_d  = state_q;
		ptr_d    = ptr_q;
		done_d   = 1'b0;
		result_d = result_q;
		ram_we   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (cmd.op)
						OP_LOAD: begin
							ram_we   = (32'(cmd.entry_index) < 32'(MAX_SECTIONS));
							done_d   = 1'b1;
							result_d = '{translated: '0, status: ST_LOADED};
						end
						OP_V2F, OP_F2V: begin
							if (cmd.address < header_size_q) begin
								done_d   = 1'b1;
								result_d = '{translated: cmd.address, status: ST_IDENTITY};
							end else if (cmd.op == OP_V2F && cmd.address >= image_size_q) begin
								done_d   = 1'b1;
								result_d = '{translated: '0, status: ST_RANGE};
							end else if (valid_cnt == '0) begin
								done_d   = 1'b1;
								result_d = '{translated: '0, status: ST_NOTFOUND};
							end else begin
								ptr_d   = IDX_W'(valid_cnt - CNT_W'(1));
								state_d = (cmd.op == OP_F2V) ? S_END_RD : S_RD;
							end
						end
						default: begin
							done_d   = 1'b1;
							result_d = '{translated: '0, status: ST_RANGE};
						end
					endcase
				end
			end
			S_END_RD: begin
				state_d = S_END_CHK;
			end
			S_END_CHK: begin
				if ({1'b0, addr_q} >= section_end) begin
					done_d   = 1'b1;
					result_d = '{translated: '0, status: ST_RANGE};
					state_d  = S_IDLE;
				end else begin
					state_d = S_CMP;
				end
			end
			S_RD: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				if (addr_q >= from_base) begin
					done_d   = 1'b1;
					result_d = '{translated: addr_q - from_base + to_base,
						status: ST_TRANSLATED};
					state_d  = S_IDLE;
				end else if (ptr_q == '0) begin
					done_d   = 1'b1;
					result_d = '{translated: '0, status: ST_NOTFOUND};
					state_d  = S_IDLE;
				end else begin
					ptr_d   = ptr_q - IDX_W'(1);
					state_d = S_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// A result beat is only ever issued as the sequencer returns to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while a search is still running");

	a_load_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.op == OP_LOAD) |=> (done && result.status == ST_LOADED))
		else $error("load not acknowledged in the following cycle");

	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_IDENTITY && result.status != ST_TRANSLATED)
			|-> (result.translated == '0))
		else $error("nonzero address with a failing status");

	a_end_check_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_END_CHK) |-> ($past(state_q) == S_END_RD))
		else $error("end check without reading the last entry first");

endmodule
